// File: hw/rtl/cms_pkg.sv
// Package for the capacitance measurement sequencer: request/response structs,
// phase and control enums, register indexes, constants and small helpers.
// No dependencies.
package cms_pkg;

   localparam int ADC_BITS  = 10;
   localparam int TIME_BITS = 22;
   localparam int CAP_BITS  = 42;
   localparam int LOG_BITS  = 19;
   localparam int CSR_BITS  = 22;

   localparam logic [ADC_BITS-1:0]  ADC_MAX  = {ADC_BITS{1'b1}};
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [CAP_BITS-1:0]  CAP_MAX  = {CAP_BITS{1'b1}};
   localparam logic [LOG_BITS-1:0]  LOG_MAX  = {LOG_BITS{1'b1}};
   localparam logic [31:0]          LN2_Q32  = 32'd2977044472;
   localparam logic [9:0]           US_PER_MS = 10'd1000;
   localparam logic [9:0]           PF_PER_NF = 10'd1000;
   localparam logic [6:0]           DIV_STEPS = 7'd64;
   localparam logic [4:0]           LG_TOP_BIT = 5'd27;

   typedef enum logic [2:0] {
      CSR_STRAY_CAP   = 3'd0,
      CSR_PULLUP      = 3'd1,
      CSR_DIV_LIMIT   = 3'd2,
      CSR_TIMEOUT     = 3'd3,
      CSR_SETTLE      = 3'd4,
      CSR_DIS_FACTOR  = 3'd5,
      CSR_PERIOD      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      LEAD_INPUT  = 2'd0,
      LEAD_PULLUP = 2'd1,
      LEAD_LOW    = 2'd2,
      LEAD_HIGH   = 2'd3
   } lead_mode_type;

   typedef enum logic [1:0] {
      RK_DIVIDER = 2'd0,
      RK_CHARGE  = 2'd1,
      RK_TIMEOUT = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      PH_START     = 3'd0,
      PH_DIVREAD   = 3'd1,
      PH_SETTLE    = 3'd2,
      PH_CHARGE    = 3'd3,
      PH_CHGREAD   = 3'd4,
      PH_DISCHARGE = 3'd5,
      PH_IDLE      = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_LOG,
      CTL_LOG_MUL,
      CTL_LOG_RND,
      CTL_RL,
      CTL_DIV_CHK,
      CTL_DIV,
      CTL_DONE
   } ctl_type;

   typedef struct packed {
      logic                kind;
      logic [ADC_BITS-1:0] adc_value;
      logic                lead_high;
   } req_type;

   typedef struct packed {
      logic [1:0]           lead_p_mode;
      logic [1:0]           lead_n_mode;
      logic                 adc_start;
      logic                 adc_channel;
      logic                 result_valid;
      logic [1:0]           result_kind;
      logic [CAP_BITS-1:0]  capacitance;
      logic [TIME_BITS-1:0] charge_time_us;
      logic [ADC_BITS-1:0]  conv_code;
   } rsp_type;

   function automatic logic [TIME_BITS-1:0] inc_sat(input logic [TIME_BITS-1:0] v);
      return (v == TIME_MAX) ? v : v + 1'b1;
   endfunction

   // Base-2 log in Q28 by repeated squaring, for elaboration-time constants
   function automatic logic [31:0] lg_q28_const(input logic [31:0] x);
      logic [63:0] m;
      logic [31:0] res;
      int          msb;
      msb = 0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) msb = i;
      end
      m   = 64'(x) << (30 - msb);
      res = 32'(msb) << 28;
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m      = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   localparam logic [31:0] LG_ADC_MAX = lg_q28_const(32'(ADC_MAX));

endpackage

// File: hw/rtl/capacitance_measurement_sequencer.sv
// Capacitance measurement sequencer: one request per tick or ADC completion,
// one response per request. Depends on cms_pkg.
//
// Each request yields exactly one response. Ticks and requests that need no
// arithmetic go straight to the done state. A divider-method result runs a
// 64-step bit-serial restoring divide; a charge-method result first runs a
// 28-step squaring loop for the logarithm on one 31x31 multiplier and three
// pipeline steps for scaling, then the same divide. A new request is taken
// once the previous one has moved into the response register, even while
// that response still waits to be taken. No clearing pass after reset.
module capacitance_measurement_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  cms_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cms_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [2:0]                   csr_index,
   input  logic [cms_pkg::CSR_BITS-1:0] csr_wdata
);
   import cms_pkg::*;

   // configuration
   logic [15:0]          stray_ff, pullup_ff, settle_ff;
   logic [ADC_BITS-1:0]  limit_ff;
   logic [TIME_BITS-1:0] timeout_ff, period_cfg_ff;
   logic [3:0]           factor_ff;

   // measurement state
   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] step_ff, step_in, period_ff, period_in, chg_time_ff, chg_time_in;
   logic [9:0]           chg_mod_ff, chg_mod_in;
   logic [12:0]          chg_ms_ff, chg_ms_in;
   logic                 timed_out_ff, timed_out_in;
   logic [15:0]          dis_ms_ff, dis_ms_in;

   // arithmetic control and datapath
   ctl_type              ctl_ff, ctl_in;
   logic [30:0]          m_ff, m_in;
   logic [31:0]          lg_ff, lg_in;
   logic [4:0]           pos_ff, pos_in;
   logic [63:0]          prod_ff, prod_in;
   logic [LOG_BITS-1:0]  l_ff, l_in;
   logic [34:0]          d_ff, d_in, rem_ff, rem_in;
   logic [63:0]          num_ff, num_in;
   logic [CAP_BITS-1:0]  q_ff, q_in;
   logic                 sat_ff, sat_in, calc_ff, calc_in;
   logic [6:0]           cnt_ff, cnt_in;
   rsp_type              wrk_ff, wrk_in, rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic                 req_fire, tick, out_free, load_out;
   logic                 calc_div, calc_chg;
   logic [TIME_BITS-1:0] st_inc, ct_inc;
   logic [61:0]          sq;
   logic [31:0]          sq_top;
   logic [64:0]          rnd;
   logic [20:0]          rnd_v;
   logic [35:0]          div_t, div_diff;
   logic                 div_ge;
   logic [ADC_BITS-1:0]  log_x;
   logic [3:0]           log_msb;

   assign req_ready = (ctl_ff == CTL_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign tick      = !req_data.kind;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign st_inc = inc_sat(step_ff);
   assign ct_inc = inc_sat(chg_time_ff);

   // measurement phase sequencing, applied on an accepted request
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      period_in    = tick ? inc_sat(period_ff) : period_ff;
      chg_time_in  = chg_time_ff;
      chg_mod_in   = chg_mod_ff;
      chg_ms_in    = chg_ms_ff;
      timed_out_in = timed_out_ff;
      dis_ms_in    = dis_ms_ff;
      calc_div     = 1'b0;
      calc_chg     = 1'b0;
      wrk_in       = '0;
      unique case (phase_ff)
         PH_DIVREAD: begin
            if (!tick) begin
               if (req_data.adc_value < limit_ff) begin
                  wrk_in.result_valid = 1'b1;
                  wrk_in.result_kind  = RK_DIVIDER;
                  wrk_in.conv_code    = req_data.adc_value;
                  calc_div            = 1'b1;
                  phase_in            = PH_IDLE;
               end else begin
                  step_in  = '0;
                  phase_in = PH_SETTLE;
               end
            end
         end
         PH_SETTLE: begin
            if (tick) begin
               step_in = st_inc;
               if (st_inc >= TIME_BITS'(settle_ff)) begin
                  chg_time_in  = '0;
                  chg_mod_in   = '0;
                  chg_ms_in    = '0;
                  timed_out_in = 1'b0;
                  phase_in     = PH_CHARGE;
               end
            end
         end
         PH_CHARGE: begin
            if (tick) begin
               chg_time_in = ct_inc;
               // track whole milliseconds alongside the saturating count
               if (chg_time_ff != TIME_MAX) begin
                  if (chg_mod_ff == US_PER_MS - 10'd1) begin
                     chg_mod_in = '0;
                     chg_ms_in  = chg_ms_ff + 13'd1;
                  end else begin
                     chg_mod_in = chg_mod_ff + 10'd1;
                  end
               end
               if (req_data.lead_high || ct_inc >= timeout_ff) begin
                  timed_out_in     = !req_data.lead_high;
                  phase_in         = PH_CHGREAD;
                  wrk_in.adc_start = 1'b1;
               end
            end
         end
         PH_CHGREAD: begin
            if (!tick) begin
               wrk_in.result_valid   = 1'b1;
               wrk_in.result_kind    = timed_out_ff ? RK_TIMEOUT : RK_CHARGE;
               wrk_in.conv_code      = req_data.adc_value;
               wrk_in.charge_time_us = chg_time_ff;
               calc_chg              = 1'b1;
               dis_ms_in             = 16'(chg_ms_ff * factor_ff);
               step_in               = '0;
               phase_in              = (dis_ms_in != '0) ? PH_DISCHARGE : PH_IDLE;
            end
         end
         PH_DISCHARGE: begin
            if (tick) begin
               step_in = st_inc;
               if (st_inc >= TIME_BITS'(US_PER_MS)) begin
                  step_in = '0;
                  if (dis_ms_ff != '0) dis_ms_in = dis_ms_ff - 16'd1;
                  if (dis_ms_in == '0) phase_in = PH_IDLE;
               end
            end
         end
         PH_IDLE: begin
            if (tick && period_in >= period_cfg_ff) begin
               period_in        = '0;
               phase_in         = PH_DIVREAD;
               wrk_in.adc_start = 1'b1;
            end
         end
         default: begin
            period_in        = '0;
            phase_in         = PH_DIVREAD;
            wrk_in.adc_start = 1'b1;
         end
      endcase
      unique case (phase_in)
         PH_DIVREAD:   begin wrk_in.lead_p_mode = LEAD_HIGH;   wrk_in.lead_n_mode = LEAD_INPUT; end
         PH_SETTLE:    begin wrk_in.lead_p_mode = LEAD_LOW;    wrk_in.lead_n_mode = LEAD_LOW;   end
         PH_CHARGE:    begin wrk_in.lead_p_mode = LEAD_PULLUP; wrk_in.lead_n_mode = LEAD_LOW;   end
         PH_CHGREAD:   begin wrk_in.lead_p_mode = LEAD_INPUT;  wrk_in.lead_n_mode = LEAD_LOW;   end
         PH_DISCHARGE: begin wrk_in.lead_p_mode = LEAD_INPUT;  wrk_in.lead_n_mode = LEAD_HIGH;  end
         PH_IDLE:      begin wrk_in.lead_p_mode = LEAD_LOW;    wrk_in.lead_n_mode = LEAD_LOW;   end
         default:      begin wrk_in.lead_p_mode = LEAD_INPUT;  wrk_in.lead_n_mode = LEAD_INPUT; end
      endcase
      wrk_in.adc_channel = (phase_in == PH_CHGREAD);
   end

   // arithmetic datapath helpers
   assign log_x  = ADC_MAX - req_data.adc_value;
   always_comb begin
      log_msb = '0;
      for (int i = 0; i < ADC_BITS; i++) begin
         if (log_x[i]) log_msb = 4'(i);
      end
   end
   assign sq       = {31'b0, m_ff} * {31'b0, m_ff};
   assign sq_top   = sq[61:30];
   assign rnd      = {1'b0, prod_ff} + (65'd1 << 43);
   assign rnd_v    = rnd[64:44];
   assign div_t    = {rem_ff, num_ff[63]};
   assign div_diff = div_t - {1'b0, d_ff};
   assign div_ge   = (div_t >= {1'b0, d_ff});

   always_comb begin
      ctl_in   = ctl_ff;
      m_in     = m_ff;
      lg_in    = lg_ff;
      pos_in   = pos_ff;
      prod_in  = prod_ff;
      l_in     = l_ff;
      d_in     = d_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;
      cnt_in   = cnt_ff;
      calc_in  = calc_ff;
      load_out = 1'b0;
      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req_fire) begin
               calc_in = calc_div || calc_chg;
               if (calc_div) begin
                  num_in = {38'b0, 26'(req_data.adc_value * stray_ff)};
                  d_in   = 35'(log_x);
                  ctl_in = CTL_DIV_CHK;
               end else if (calc_chg) begin
                  num_in = {32'(PF_PER_NF * chg_time_ff), 32'b0};
                  if (req_data.adc_value == '0) begin
                     l_in   = '0;
                     ctl_in = CTL_RL;
                  end else if (req_data.adc_value == ADC_MAX) begin
                     l_in   = LOG_MAX;
                     ctl_in = CTL_RL;
                  end else begin
                     m_in   = 31'(log_x) << (5'd30 - 5'(log_msb));
                     lg_in  = {log_msb, 28'b0};
                     pos_in = LG_TOP_BIT;
                     ctl_in = CTL_LOG;
                  end
               end else begin
                  ctl_in = CTL_DONE;
               end
            end
         end
         CTL_LOG: begin
            // square, renormalize, emit one fraction bit
            if (sq_top[31]) begin
               m_in          = sq_top[31:1];
               lg_in[pos_ff] = 1'b1;
            end else begin
               m_in = sq_top[30:0];
            end
            if (pos_ff == '0) ctl_in = CTL_LOG_MUL;
            else pos_in = pos_ff - 5'd1;
         end
         CTL_LOG_MUL: begin
            prod_in = {32'b0, LG_ADC_MAX - lg_ff} * {32'b0, LN2_Q32};
            ctl_in  = CTL_LOG_RND;
         end
         CTL_LOG_RND: begin
            l_in   = (rnd_v > 21'(LOG_MAX)) ? LOG_MAX : rnd_v[LOG_BITS-1:0];
            ctl_in = CTL_RL;
         end
         CTL_RL: begin
            d_in   = 35'({19'b0, pullup_ff} * {16'b0, l_ff});
            ctl_in = CTL_DIV_CHK;
         end
         CTL_DIV_CHK: begin
            rem_in = '0;
            q_in   = '0;
            cnt_in = DIV_STEPS;
            sat_in = (d_ff == '0);
            ctl_in = (d_ff == '0) ? CTL_DONE : CTL_DIV;
         end
         CTL_DIV: begin
            rem_in = div_ge ? div_diff[34:0] : div_t[34:0];
            num_in = {num_ff[62:0], 1'b0};
            q_in   = {q_ff[CAP_BITS-2:0], div_ge};
            sat_in = sat_ff || q_ff[CAP_BITS-1];
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) ctl_in = CTL_DONE;
         end
         CTL_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               ctl_in   = CTL_IDLE;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      rsp_in             = wrk_ff;
      rsp_in.capacitance = calc_ff ? (sat_ff ? CAP_MAX : q_ff) : '0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stray_ff      <= 16'd6267;
         pullup_ff     <= 16'd8909;
         limit_ff      <= 10'd1000;
         timeout_ff    <= 22'd400000;
         settle_ff     <= 16'd1000;
         factor_ff     <= 4'd5;
         period_cfg_ff <= 22'd1000000;
         phase_ff      <= PH_START;
         step_ff       <= '0;
         period_ff     <= '0;
         chg_time_ff   <= '0;
         chg_mod_ff    <= '0;
         chg_ms_ff     <= '0;
         timed_out_ff  <= 1'b0;
         dis_ms_ff     <= '0;
         ctl_ff        <= CTL_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STRAY_CAP:  stray_ff      <= csr_wdata[15:0];
               CSR_PULLUP:     pullup_ff     <= csr_wdata[15:0];
               CSR_DIV_LIMIT:  limit_ff      <= csr_wdata[ADC_BITS-1:0];
               CSR_TIMEOUT:    timeout_ff    <= csr_wdata[TIME_BITS-1:0];
               CSR_SETTLE:     settle_ff     <= csr_wdata[15:0];
               CSR_DIS_FACTOR: factor_ff     <= csr_wdata[3:0];
               CSR_PERIOD:     period_cfg_ff <= csr_wdata[TIME_BITS-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            phase_ff     <= phase_in;
            step_ff      <= step_in;
            period_ff    <= period_in;
            chg_time_ff  <= chg_time_in;
            chg_mod_ff   <= chg_mod_in;
            chg_ms_ff    <= chg_ms_in;
            timed_out_ff <= timed_out_in;
            dis_ms_ff    <= dis_ms_in;
         end
         ctl_ff <= ctl_in;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      lg_ff   <= lg_in;
      pos_ff  <= pos_in;
      prod_ff <= prod_in;
      l_ff    <= l_in;
      d_ff    <= d_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
      cnt_ff  <= cnt_in;
      calc_ff <= calc_in;
      if (req_fire) wrk_ff <= wrk_in;
      if (load_out) rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (ctl_ff != CTL_IDLE))
      else $error("control returned idle right after a request");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == CTL_DIV) |-> (cnt_ff != '0))
      else $error("divide running with zero step count");

   a_divider_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_valid && rsp_ff.result_kind == RK_DIVIDER)
      |-> (rsp_ff.charge_time_us == '0))
      else $error("divider result carries a charge time");
`endif

endmodule

// File: sim/tb_capacitance_measurement_sequencer.sv
// Testbench for the capacitance measurement sequencer: directed and random
// tick/ADC requests checked against a cycle-free predictor of the sequencer.
// Depends on cms_pkg and the capacitance_measurement_sequencer RTL.
module tb_capacitance_measurement_sequencer;
   import cms_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RAND_PER_SET = 50;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [2:0] csr_index;
   logic [CSR_BITS-1:0] csr_wdata;

   capacitance_measurement_sequencer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [21:0] reg_val [7];
   phase_type seq_phase;
   logic [TIME_BITS-1:0] step_count;
   logic [TIME_BITS-1:0] period_count;
   logic [TIME_BITS-1:0] charge_us;
   bit charge_gave_up;
   longint unsigned discharge_ms;
   bit saw_discharge;

   rsp_type rsp_due [$];
   int errors;
   int cycles;
   int idle_mode;
   int hold_left;
   int set_no;

   typedef struct {
      logic kind;
      logic [ADC_BITS-1:0] adc;
      logic lead;
      bit typed;
      rsp_type want;
   } row_type;

   row_type rows [22];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [TIME_BITS-1:0] bump(input logic [TIME_BITS-1:0] v);
      return (v == TIME_MAX) ? v : v + 1'b1;
   endfunction

   function automatic longint unsigned log2_q28(input int unsigned x);
      int msb;
      longint unsigned m, res;
      msb = 0;
      for (int i = 0; i < 32; i++) if ((x >> i) & 1) msb = i;
      m = longint'(x) << (30 - msb);
      res = longint'(msb) << 28;
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            res = res | (64'd1 << i);
         end
      end
      return res;
   endfunction

   // -ln(1 - a/ADC_MAX) in Q3.16, saturated
   function automatic longint unsigned neg_ln_q16(input int unsigned a);
      longint unsigned hi, lo, v;
      if (a >= 1023) return 64'h7FFFF;
      hi = log2_q28(1023);
      lo = log2_q28(1023 - a);
      if (lo >= hi) return 0;
      v = ((hi - lo) * 64'd2977044472 + (64'd1 << 43)) >> 44;
      return (v > 64'h7FFFF) ? 64'h7FFFF : v;
   endfunction

   function automatic longint unsigned cap_quotient(input longint unsigned n,
                                                    input int sh,
                                                    input longint unsigned d);
      longint unsigned q, r, top;
      top = (64'd1 << CAP_BITS) - 1;
      if (d == 0) return top;
      q = n / d;
      r = n % d;
      if (q > top) return top;
      for (int i = 0; i < sh; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
         if (q > top) return top;
      end
      return q;
   endfunction

   function automatic lead_mode_type p_mode(input phase_type p);
      case (p)
         PH_DIVREAD: return LEAD_HIGH;
         PH_SETTLE, PH_IDLE: return LEAD_LOW;
         PH_CHARGE: return LEAD_PULLUP;
         default: return LEAD_INPUT;
      endcase
   endfunction

   function automatic lead_mode_type n_mode(input phase_type p);
      case (p)
         PH_SETTLE, PH_CHARGE, PH_CHGREAD, PH_IDLE: return LEAD_LOW;
         PH_DISCHARGE: return LEAD_HIGH;
         default: return LEAD_INPUT;
      endcase
   endfunction

   function automatic rsp_type measure_step(input req_type r);
      rsp_type o;
      bit tick;
      o = '0;
      tick = (r.kind == 1'b0);
      if (tick) period_count = bump(period_count);
      case (seq_phase)
         PH_DIVREAD: if (!tick) begin
            if (r.adc_value < reg_val[CSR_DIV_LIMIT][9:0]) begin
               o.result_valid = 1'b1;
               o.result_kind = RK_DIVIDER;
               o.conv_code = r.adc_value;
               o.capacitance = CAP_BITS'(cap_quotient(
                                  longint'(r.adc_value) * reg_val[CSR_STRAY_CAP],
                                  0, 1023 - r.adc_value));
               seq_phase = PH_IDLE;
            end else begin
               step_count = '0;
               seq_phase = PH_SETTLE;
            end
         end
         PH_SETTLE: if (tick) begin
            step_count = bump(step_count);
            if (step_count >= reg_val[CSR_SETTLE]) begin
               charge_us = '0;
               charge_gave_up = 1'b0;
               seq_phase = PH_CHARGE;
            end
         end
         PH_CHARGE: if (tick) begin
            charge_us = bump(charge_us);
            if (r.lead_high || charge_us >= reg_val[CSR_TIMEOUT]) begin
               charge_gave_up = !r.lead_high;
               seq_phase = PH_CHGREAD;
               o.adc_start = 1'b1;
            end
         end
         PH_CHGREAD: if (!tick) begin
            o.result_valid = 1'b1;
            o.result_kind = charge_gave_up ? RK_TIMEOUT : RK_CHARGE;
            o.conv_code = r.adc_value;
            o.charge_time_us = charge_us;
            o.capacitance = CAP_BITS'(cap_quotient(64'd1000 * charge_us, 32,
                                         longint'(reg_val[CSR_PULLUP]) *
                                         neg_ln_q16(r.adc_value)));
            discharge_ms = (charge_us / 1000) * reg_val[CSR_DIS_FACTOR];
            step_count = '0;
            seq_phase = (discharge_ms != 0) ? PH_DISCHARGE : PH_IDLE;
         end
         PH_DISCHARGE: if (tick) begin
            step_count = bump(step_count);
            if (step_count >= 1000) begin
               step_count = '0;
               if (discharge_ms != 0) discharge_ms--;
               if (discharge_ms == 0) seq_phase = PH_IDLE;
            end
         end
         PH_IDLE: if (tick && period_count >= reg_val[CSR_PERIOD]) begin
            period_count = '0;
            seq_phase = PH_DIVREAD;
            o.adc_start = 1'b1;
         end
         default: begin
            period_count = '0;
            seq_phase = PH_DIVREAD;
            o.adc_start = 1'b1;
         end
      endcase
      if (seq_phase == PH_DISCHARGE) saw_discharge = 1'b1;
      o.lead_p_mode = p_mode(seq_phase);
      o.lead_n_mode = n_mode(seq_phase);
      o.adc_channel = (seq_phase == PH_CHGREAD);
      return o;
   endfunction

   task automatic report(input string field, input longint unsigned got,
                         input longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type w;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            report("unexpected response", 1, 0);
         end else begin
            w = rsp_due.pop_front();
            if (rsp_data.lead_p_mode != w.lead_p_mode)
               report("lead_p_mode", rsp_data.lead_p_mode, w.lead_p_mode);
            if (rsp_data.lead_n_mode != w.lead_n_mode)
               report("lead_n_mode", rsp_data.lead_n_mode, w.lead_n_mode);
            if (rsp_data.adc_start != w.adc_start)
               report("adc_start", rsp_data.adc_start, w.adc_start);
            if (rsp_data.adc_channel != w.adc_channel)
               report("adc_channel", rsp_data.adc_channel, w.adc_channel);
            if (rsp_data.result_valid != w.result_valid)
               report("result_valid", rsp_data.result_valid, w.result_valid);
            if (rsp_data.result_kind != w.result_kind)
               report("result_kind", rsp_data.result_kind, w.result_kind);
            if (rsp_data.capacitance != w.capacitance)
               report("capacitance", rsp_data.capacitance, w.capacitance);
            if (rsp_data.charge_time_us != w.charge_time_us)
               report("charge_time_us", rsp_data.charge_time_us, w.charge_time_us);
            if (rsp_data.conv_code != w.conv_code)
               report("conv_code", rsp_data.conv_code, w.conv_code);
         end
      end
   end

   // receiver: long hold-off first, then random stalls per mode
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else if (idle_mode == 2) rsp_ready = ($urandom_range(0, 99) >= 51);
      else if (idle_mode == 3) rsp_ready = ($urandom_range(0, 99) >= 9);
      else rsp_ready = 1'b1;
   end

   // call at a falling edge; returns at a falling edge with valid still high
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type got;
      while ((idle_mode == 1 && $urandom_range(0, 99) < 51) ||
             (idle_mode == 3 && $urandom_range(0, 99) < 9)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      got = measure_step(r);
      rsp_due.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid = 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic load_settings(input int k);
      logic [21:0] v [7];
      drain();
      case (k)
         0: v = '{65535, 1, 1023, 1, 0, 15, 1};
         1: v = '{0, 0, 0, 0, 0, 0, 0};
         2: v = '{1, 65535, 512, 4194303, 65535, 15, 4194303};
         5: v = '{$urandom_range(0, 65535), $urandom_range(1, 65535), 0, 1000, 0, 1, 1};
         default: v = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 1023), $urandom_range(1, 80),
                        $urandom_range(0, 10), $urandom_range(0, 15),
                        $urandom_range(1, 150)};
      endcase
      // settings after the extreme ones must leave the long settle behind
      if (k == 3) v[CSR_SETTLE] = 0;
      for (int i = 0; i < 7; i++) begin
         csr_wr_en = 1'b1;
         csr_index = csr_index_type'(i);
         csr_wdata = v[i];
         reg_val[i] = v[i];
         @(negedge clock);
      end
      csr_wr_en = 1'b0;
      reg_val[CSR_STRAY_CAP] &= 22'hFFFF;
      reg_val[CSR_PULLUP] &= 22'hFFFF;
      reg_val[CSR_DIV_LIMIT] &= 22'h3FF;
      reg_val[CSR_SETTLE] &= 22'hFFFF;
      reg_val[CSR_DIS_FACTOR] &= 22'hF;
   endtask

   function automatic req_type random_request(input int k);
      req_type r;
      bit want_adc;
      want_adc = (seq_phase == PH_DIVREAD || seq_phase == PH_CHGREAD) ?
                 ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 10);
      r.kind = want_adc;
      case ($urandom_range(0, 9))
         0: r.adc_value = 10'd0;
         1: r.adc_value = 10'd1023;
         default: r.adc_value = ADC_BITS'($urandom_range(0, 1023));
      endcase
      if (seq_phase == PH_CHARGE) r.lead_high = (k == 5) ? 1'b0 : ($urandom_range(0, 5) == 0);
      else r.lead_high = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic row_type mk(input logic kind, input int adc, input logic lead);
      row_type t;
      t.kind = kind;
      t.adc = ADC_BITS'(adc);
      t.lead = lead;
      t.typed = 1'b0;
      t.want = '0;
      return t;
   endfunction

   initial begin
      req_type r;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_STRAY_CAP;
      csr_wdata = '0;
      errors = 0;
      cycles = 0;
      idle_mode = 0;
      hold_left = 0;
      reg_val = '{6267, 8909, 1000, 400000, 1000, 5, 1000000};
      seq_phase = PH_START;
      step_count = '0;
      period_count = '0;
      charge_us = '0;
      charge_gave_up = 1'b0;
      discharge_ms = 0;
      saw_discharge = 1'b0;

      // first request after reset opens a period; ADC zero gives zero pF
      rows[0] = mk(0, 0, 0);
      rows[0].typed = 1'b1;
      rows[0].want.lead_p_mode = LEAD_HIGH;
      rows[0].want.lead_n_mode = LEAD_INPUT;
      rows[0].want.adc_start = 1'b1;
      rows[1] = mk(1, 0, 0);
      rows[1].typed = 1'b1;
      rows[1].want.lead_p_mode = LEAD_LOW;
      rows[1].want.lead_n_mode = LEAD_LOW;
      rows[1].want.result_valid = 1'b1;
      rows[1].want.result_kind = RK_DIVIDER;
      // extreme settings: divider at top reading, settle of zero,
      // lead high together with timeout, full-scale charge reading
      rows[2] = mk(0, 0, 0);
      rows[3] = mk(1, 1022, 1);
      rows[4] = mk(0, 1023, 0);
      rows[5] = mk(1, 1023, 0);
      rows[6] = mk(0, 0, 0);
      rows[7] = mk(0, 0, 1);
      rows[8] = mk(1, 1023, 1);
      rows[9] = mk(1, 5, 0);
      rows[10] = mk(0, 0, 0);
      rows[11] = mk(1, 1023, 0);
      rows[12] = mk(0, 0, 0);
      rows[13] = mk(0, 0, 0);
      rows[14] = mk(1, 0, 0);
      rows[15] = mk(0, 1023, 1);
      // all-zero settings: zero timeout, zero pull-up, zero period
      rows[16] = mk(1, 0, 0);
      rows[17] = mk(0, 0, 0);
      rows[18] = mk(0, 0, 0);
      rows[19] = mk(1, 700, 0);
      rows[20] = mk(0, 0, 1);
      rows[21] = mk(1, 341, 1);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 22; i++) begin
         if (i == 2) load_settings(0);
         if (i == 16) load_settings(1);
         r.kind = rows[i].kind;
         r.adc_value = rows[i].adc;
         r.lead_high = rows[i].lead;
         send_request(r, rows[i].typed, rows[i].want);
      end

      for (set_no = 2; set_no < 10; set_no++) begin
         load_settings(set_no);
         idle_mode = set_no % 4;
         saw_discharge = 1'b0;
         // fill the block while responses are held back
         if (set_no == 3) hold_left = 400;
         for (int n = 0; n < RAND_PER_SET ||
              (set_no == 5 && !(saw_discharge && seq_phase == PH_IDLE)); n++)
            send_request(random_request(set_no), 1'b0, '0);
      end

      drain();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
